// ----- design/rigid_body_2d_integrator_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Rigid body integrator assertion macros
// Concurrent assertion wrappers, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef RIGID_BODY_2D_INTEGRATOR_UNIT_ASSERT_SVH
`define RIGID_BODY_2D_INTEGRATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// checked outside reset
`define RBI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked during reset too
`define RBI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RBI_ASSERT(lbl, prop, msg)
`define RBI_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- design/rbi_pkg.sv -----
// ----------------------------------------------------------------------------
// Rigid body integrator package
// Payload types, register map, state codes and saturation helpers.
// ----------------------------------------------------------------------------
package rbi_pkg;

  localparam int RBI_FRAC_BITS = 16;
  localparam int RBI_ADDR_W    = 5;

  typedef struct packed {
    logic               command;
    logic signed [31:0] push_x;
    logic signed [31:0] push_y;
    logic signed [31:0] contact_x;
    logic signed [31:0] contact_y;
    logic        [15:0] time_step;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic signed [31:0] heading;
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic signed [31:0] spin_rate;
  } out_item_t;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_INV_MASS    = 3'd0;
  localparam logic [2:0] REG_INV_INERTIA = 3'd1;
  localparam logic [2:0] REG_MAX_LIN     = 3'd2;
  localparam logic [2:0] REG_MAX_ANG     = 3'd3;
  localparam logic [2:0] REG_LIN_DAMP    = 3'd4;
  localparam logic [2:0] REG_ANG_DAMP    = 3'd5;
  localparam logic [2:0] REG_MIN_LIN     = 3'd6;
  localparam logic [2:0] REG_MIN_ANG     = 3'd7;

  localparam logic CMD_FORCE     = 1'b0;
  localparam logic CMD_INTEGRATE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  typedef enum logic [4:0] {
    OP_AX, OP_VX, OP_AY, OP_VY, OP_SQX, OP_SQY, OP_SQRT,
    OP_NX, OP_DX, OP_NY, OP_DY, OP_ALPHA, OP_W,
    OP_DVX, OP_DVY, OP_DW, OP_PX, OP_PY, OP_PA,
    OP_T1, OP_T2
  } op_e;

  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) return 32'sh7fffffff;
    else if (v < lo) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) return s[32] ? 32'sh80000000 : 32'sh7fffffff;
    else return s[31:0];
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} - {b[31], b};
    if (s[32] != s[31]) return s[32] ? 32'sh80000000 : 32'sh7fffffff;
    else return s[31:0];
  endfunction

  function automatic logic [32:0] mag33(input logic signed [31:0] v);
    logic signed [32:0] w;
    w = {v[31], v};
    return v[31] ? 33'(-w) : 33'(w);
  endfunction

endpackage

// ----- design/rigid_body_2d_integrator_unit.sv -----
// ----------------------------------------------------------------------------
// Rigid body 2D integrator unit
// Fixed-point semi-implicit Euler integrator for one body, built around a
// micro-step sequencer and shared bit-serial multiply, root and divide units.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-------------------------
//  in       | sink      | in_valid_i/in_stall_o  | in_data_i  (in_item_t)
//  out      | source    | out_valid_o/out_stall_i| out_data_o (out_item_t)
//  cfg      | sink      | APB psel/penable       | pwdata/prdata, 8 regs
//
//  Work: a force transaction takes two serial multiplies. An integrate takes
//  14 multiplies and a root; when the speed clamp engages, two more
//  multiplies and two divides follow. An integrate on a frozen body (zero
//  inverse mass) goes straight to the result. One transaction at a time.
//  Reset clears the body state and loads the register defaults; no sweep.
//  A stalled result sits in the output register while the next transaction
//  is accepted and worked on.
// ----------------------------------------------------------------------------
module rigid_body_2d_integrator_unit #(
  parameter int FRAC_BITS = rbi_pkg::RBI_FRAC_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  rbi_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output rbi_pkg::out_item_t              out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rbi_pkg::RBI_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import rbi_pkg::*;

  `include "rigid_body_2d_integrator_unit_assert.svh"

  // ---------------- configuration registers ----------------
  logic [30:0] inv_mass_q, inv_inertia_q, max_lin_q, max_ang_q;
  logic [30:0] min_lin_q, min_ang_q;
  logic [16:0] lin_damp_q, ang_damp_q;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_mass_q    <= 31'd65536;
      inv_inertia_q <= 31'd65536;
      max_lin_q     <= 31'h7fffffff;
      max_ang_q     <= 31'h7fffffff;
      lin_damp_q    <= 17'd65536;
      ang_damp_q    <= 17'd65536;
      min_lin_q     <= '0;
      min_ang_q     <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_INV_MASS:    inv_mass_q    <= pwdata[30:0];
        REG_INV_INERTIA: inv_inertia_q <= pwdata[30:0];
        REG_MAX_LIN:     max_lin_q     <= pwdata[30:0];
        REG_MAX_ANG:     max_ang_q     <= pwdata[30:0];
        REG_LIN_DAMP:    lin_damp_q    <= pwdata[16:0];
        REG_ANG_DAMP:    ang_damp_q    <= pwdata[16:0];
        REG_MIN_LIN:     min_lin_q     <= pwdata[30:0];
        REG_MIN_ANG:     min_ang_q     <= pwdata[30:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_INV_MASS:    prdata = {1'b0, inv_mass_q};
      REG_INV_INERTIA: prdata = {1'b0, inv_inertia_q};
      REG_MAX_LIN:     prdata = {1'b0, max_lin_q};
      REG_MAX_ANG:     prdata = {1'b0, max_ang_q};
      REG_LIN_DAMP:    prdata = {15'd0, lin_damp_q};
      REG_ANG_DAMP:    prdata = {15'd0, ang_damp_q};
      REG_MIN_LIN:     prdata = {1'b0, min_lin_q};
      REG_MIN_ANG:     prdata = {1'b0, min_ang_q};
      default:         prdata = '0;
    endcase
  end

  // ---------------- body state ----------------
  logic signed [31:0] fax_q, fay_q, torque_q;
  logic signed [31:0] px_q, py_q, ang_q, vx_q, vy_q, spin_q;
  // scratch
  logic signed [31:0] tmp_q, w_q;
  logic signed [63:0] tw_q;      // first torque product, already shifted
  logic        [63:0] sq_q;      // squared speed, then divide numerator
  logic        [31:0] speed_q;
  logic               nneg_q;    // sign of component being rescaled
  in_item_t           in_q;

  state_e state_q;
  op_e    op_q;

  // ---------------- shared units ----------------
  logic               mul_start, sqrt_start, div_start;
  logic               mul_busy, sqrt_busy, div_busy;
  logic               mul_done, sqrt_done, div_done;
  logic signed [32:0] op_a, op_b;
  logic        [63:0] mul_mag;
  logic               mul_neg;
  logic        [31:0] root, quot;

  rbi_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(op_a), .b_i(op_b),
    .busy_o(mul_busy), .done_o(mul_done), .mag_o(mul_mag), .neg_o(mul_neg)
  );

  rbi_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sqrt_start), .x_i(sq_q),
    .busy_o(sqrt_busy), .done_o(sqrt_done), .root_o(root)
  );

  rbi_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(sq_q), .den_i(speed_q),
    .busy_o(div_busy), .done_o(div_done), .quot_o(quot)
  );

  // signed product, floor shift (arithmetic shift is floor), saturated Q value
  logic signed [63:0] prod, prod_sh;
  logic signed [31:0] qm;
  assign prod    = mul_neg ? -$signed(mul_mag) : $signed(mul_mag);
  assign prod_sh = prod >>> FRAC_BITS;
  assign qm      = sat64(prod_sh);

  // lever arm from the latched contact point
  logic signed [31:0] rx, ry;
  assign rx = sat_sub(in_q.contact_x, px_q);
  assign ry = sat_sub(in_q.contact_y, py_q);

  logic signed [32:0] dt33;
  assign dt33 = {17'd0, in_q.time_step};

  // operand select per micro-step
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (op_q)
      OP_AX:    begin op_a = {fax_q[31], fax_q}; op_b = {2'b00, inv_mass_q}; end
      OP_AY:    begin op_a = {fay_q[31], fay_q}; op_b = {2'b00, inv_mass_q}; end
      OP_VX, OP_VY, OP_W: begin
        op_a = {tmp_q[31], tmp_q}; op_b = dt33;
      end
      OP_SQX:   begin op_a = {vx_q[31], vx_q}; op_b = {vx_q[31], vx_q}; end
      OP_SQY:   begin op_a = {vy_q[31], vy_q}; op_b = {vy_q[31], vy_q}; end
      OP_NX:    begin op_a = {vx_q[31], vx_q}; op_b = {2'b00, max_lin_q}; end
      OP_NY:    begin op_a = {vy_q[31], vy_q}; op_b = {2'b00, max_lin_q}; end
      OP_ALPHA: begin op_a = {torque_q[31], torque_q}; op_b = {2'b00, inv_inertia_q}; end
      OP_DVX:   begin op_a = {vx_q[31], vx_q}; op_b = {16'd0, lin_damp_q}; end
      OP_DVY:   begin op_a = {vy_q[31], vy_q}; op_b = {16'd0, lin_damp_q}; end
      OP_DW:    begin op_a = {w_q[31], w_q}; op_b = {16'd0, ang_damp_q}; end
      OP_PX:    begin op_a = {vx_q[31], vx_q}; op_b = dt33; end
      OP_PY:    begin op_a = {vy_q[31], vy_q}; op_b = dt33; end
      OP_PA:    begin op_a = {spin_q[31], spin_q}; op_b = dt33; end
      OP_T1:    begin op_a = {rx[31], rx}; op_b = {in_q.push_y[31], in_q.push_y}; end
      OP_T2:    begin op_a = {ry[31], ry}; op_b = {in_q.push_x[31], in_q.push_x}; end
      default:  ;
    endcase
  end

  // unit launch from RUN: root, divide, or multiply
  logic run;
  assign run        = (state_q == ST_RUN);
  assign sqrt_start = run && (op_q == OP_SQRT);
  assign div_start  = run && ((op_q == OP_DX) || (op_q == OP_DY));
  assign mul_start  = run && !sqrt_start && !div_start;

  logic unit_done;
  assign unit_done = mul_done || sqrt_done || div_done;

  // final micro-step of a force or an integrate
  logic last_op;
  assign last_op = (op_q == OP_PA) || (op_q == OP_T2);

  // clamp of the old spin
  logic signed [31:0] w_clamp;
  always_comb begin
    if (mag33(spin_q) > {2'b00, max_ang_q})
      w_clamp = spin_q[31] ? -$signed({1'b0, max_ang_q}) : $signed({1'b0, max_ang_q});
    else
      w_clamp = spin_q;
  end

  logic signed [31:0] quot_s;
  assign quot_s = nneg_q ? -$signed(quot) : $signed(quot);

  // ---------------- output register ----------------
  logic      out_valid_q;
  out_item_t out_q;
  logic      out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  logic accept;
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_AX;
      out_valid_q <= 1'b0;
      fax_q    <= '0; fay_q <= '0; torque_q <= '0;
      px_q     <= '0; py_q  <= '0; ang_q    <= '0;
      vx_q     <= '0; vy_q  <= '0; spin_q   <= '0;
    end else begin
      // DONE loads the next result itself
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (in_data_i.command == CMD_INTEGRATE) begin
              op_q    <= OP_AX;
              state_q <= (inv_mass_q == '0) ? ST_DONE : ST_RUN;
            end else begin
              op_q    <= OP_T1;
              state_q <= ST_RUN;
            end
          end
        end
        ST_RUN: state_q <= ST_WAIT;
        ST_WAIT: begin
          if (unit_done) begin
            state_q <= last_op ? ST_DONE : ST_RUN;
            unique case (op_q)
              OP_AX:  op_q <= OP_VX;
              OP_VX:  begin vx_q <= sat_add(vx_q, qm); op_q <= OP_AY; end
              OP_AY:  op_q <= OP_VY;
              OP_VY:  begin vy_q <= sat_add(vy_q, qm); op_q <= OP_SQX; end
              OP_SQX: op_q <= OP_SQY;
              OP_SQY: op_q <= OP_SQRT;
              OP_SQRT: op_q <= (root > {1'b0, max_lin_q}) ? OP_NX : OP_ALPHA;
              OP_NX:  op_q <= OP_DX;
              OP_DX:  begin vx_q <= quot_s; op_q <= OP_NY; end
              OP_NY:  op_q <= OP_DY;
              OP_DY:  begin vy_q <= quot_s; op_q <= OP_ALPHA; end
              OP_ALPHA: op_q <= OP_W;
              OP_W:   op_q <= OP_DVX;
              OP_DVX: begin vx_q <= qm; op_q <= OP_DVY; end
              OP_DVY: begin vy_q <= qm; op_q <= OP_DW; end
              OP_DW:  begin spin_q <= qm; op_q <= OP_PX; end
              OP_PX:  begin px_q <= sat_add(px_q, qm); op_q <= OP_PY; end
              OP_PY:  begin py_q <= sat_add(py_q, qm); op_q <= OP_PA; end
              OP_PA: begin
                ang_q <= sat_add(ang_q, qm);
                // sleep limits, after position and heading used the values
                if (mag33(vx_q) < {2'b00, min_lin_q}) vx_q <= '0;
                if (mag33(vy_q) < {2'b00, min_lin_q}) vy_q <= '0;
                if (mag33(spin_q) < {2'b00, min_ang_q}) spin_q <= '0;
                fax_q    <= '0;
                fay_q    <= '0;
                torque_q <= '0;
              end
              OP_T1:  op_q <= OP_T2;
              OP_T2: begin
                torque_q <= sat_add(torque_q, sat64(tw_q - prod_sh));
                fax_q    <= sat_add(fax_q, in_q.push_x);
                fay_q    <= sat_add(fay_q, in_q.push_y);
              end
              default: ;
            endcase
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // scratch and payload registers
  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_data_i;
    if ((state_q == ST_WAIT) && unit_done) begin
      unique case (op_q)
        OP_AX, OP_AY: tmp_q <= qm;
        OP_ALPHA: begin tmp_q <= qm; w_q <= w_clamp; end
        OP_W:     w_q <= sat_add(w_q, qm);
        OP_SQX:   sq_q <= mul_mag;
        OP_SQY:   sq_q <= sq_q + mul_mag;
        OP_SQRT:  speed_q <= root;
        OP_NX, OP_NY: begin sq_q <= mul_mag; nneg_q <= mul_neg; end
        OP_T1:    tw_q <= prod_sh;
        default:  ;
      endcase
    end
    if ((state_q == ST_DONE) && out_free) begin
      out_q.position_x <= px_q;
      out_q.position_y <= py_q;
      out_q.heading    <= ang_q;
      out_q.velocity_x <= vx_q;
      out_q.velocity_y <= vy_q;
      out_q.spin_rate  <= spin_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------- assertions ----------------
  `RBI_ASSERT(a_accept_busy, accept |=> (state_q != ST_IDLE), "accept did not start work")
  `RBI_ASSERT(a_out_from_done, $rose(out_valid_q) |-> ($past(state_q) == ST_DONE),
              "result raised outside done")
  `RBI_ASSERT_ALWAYS(a_idle_units, (state_q == ST_IDLE) |-> !(mul_busy || sqrt_busy || div_busy),
                     "unit busy while idle")
endmodule

// ----- design/rbi_mul.sv -----
// ----------------------------------------------------------------------------
// Rigid body integrator multiplier
// Bit-serial shift-add sign-magnitude multiplier, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module rbi_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic               busy_o,
  output logic               done_o,
  output logic        [63:0] mag_o,
  output logic               neg_o
);
  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [31:0] ma_q;
  logic [64:0] p_q;
  logic        neg_q;
  logic [33:0] sum;
  logic [32:0] a_abs, b_abs;

  assign a_abs = a_i[32] ? 33'(-a_i) : 33'(a_i);
  assign b_abs = b_i[32] ? 33'(-b_i) : 33'(b_i);
  assign sum   = {1'b0, p_q[64:32]} + (p_q[0] ? {2'b00, ma_q} : 34'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q  <= a_abs[31:0];
      p_q   <= {33'd0, b_abs[31:0]};
      neg_q <= a_i[32] ^ b_i[32];
    end else if (busy_q) begin
      p_q <= {sum[32:0], p_q[31:0]} >> 1;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign mag_o  = p_q[63:0];
  assign neg_o  = neg_q;
endmodule

// ----- design/rbi_sqrt.sv -----
// ----------------------------------------------------------------------------
// Rigid body integrator square root
// Digit-by-digit floor square root, two radicand bits a cycle.
// ----------------------------------------------------------------------------
module rbi_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [31:0] root_o
);
  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [63:0] x_q;
  logic [34:0] r_q, r_n, trial;
  logic [31:0] q_q;

  assign r_n   = {r_q[32:0], x_q[63:62]};
  assign trial = {1'b0, q_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= x_i;
      r_q <= '0;
      q_q <= '0;
    end else if (busy_q) begin
      x_q <= {x_q[61:0], 2'b00};
      if (r_n >= trial) begin
        r_q <= r_n - trial;
        q_q <= {q_q[30:0], 1'b1};
      end else begin
        r_q <= r_n;
        q_q <= {q_q[30:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = q_q;
endmodule

// ----- design/rbi_div.sv -----
// ----------------------------------------------------------------------------
// Rigid body integrator divider
// Restoring unsigned divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module rbi_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [31:0] quot_o
);
  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [63:0] nq_q;   // numerator shifts out, quotient shifts in
  logic [31:0] rem_q, den_q;
  logic [32:0] rem_n;

  assign rem_n = {rem_q, nq_q[63]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nq_q  <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      if (rem_n >= {1'b0, den_q}) begin
        rem_q <= 32'(rem_n - {1'b0, den_q});
        nq_q  <= {nq_q[62:0], 1'b1};
      end else begin
        rem_q <= rem_n[31:0];
        nq_q  <= {nq_q[62:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = nq_q[31:0];
endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// Rigid body integrator testbench
// Drives force and integrate transactions with random gaps and stalls,
// predicts the body state after each one and checks every result in order.
// ----------------------------------------------------------------------------
module tb;
  import rbi_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic      psel = 1'b0;
  logic      penable = 1'b0;
  logic      pwrite = 1'b0;
  logic [RBI_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic      pready;

  rigid_body_2d_integrator_unit dut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // run limit: 800+ transactions plus gaps and stalls
  initial begin
    #(64'd20 * 64'd4000000);
    $display("== FAIL ==");
    $finish;
  end

  // predicted body: registers and state
  longint inv_m, inv_i, vmax, wmax, ldamp, adamp, vmin, wmin;
  longint fax, fay, tacc, px, py, ang, vx, vy, wr;
  out_item_t body_q[$];
  int errors = 0;
  bit hold_off = 1'b0;    // receiver pressure window
  int out_gap_max = 14;

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // product shifted with floor (arithmetic shift floors), then saturated
  function automatic longint qprod(longint a, longint b);
    return sat((a * b) >>> RBI_FRAC_BITS);
  endfunction

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint root_floor(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint shrink(longint v, longint num, longint den);
    longint unsigned q;
    q = (longint'(absl(v)) * num) / den;
    return v < 0 ? -longint'(q) : longint'(q);
  endfunction

  task automatic predict_body(input in_item_t it);
    longint ax, ay, al, w, spd;
    out_item_t r;
    if (it.command == CMD_INTEGRATE) begin
      if (inv_m != 0) begin
        ax = qprod(fax, inv_m);
        ay = qprod(fay, inv_m);
        vx = sat(vx + qprod(ax, it.time_step));
        vy = sat(vy + qprod(ay, it.time_step));
        spd = root_floor(longint'(vx * vx) + longint'(vy * vy));
        if (spd > vmax) begin
          vx = shrink(vx, vmax, spd);
          vy = shrink(vy, vmax, spd);
        end
        w = wr;
        if (absl(w) > wmax) w = w < 0 ? -wmax : wmax;
        al = qprod(tacc, inv_i);
        w = sat(w + qprod(al, it.time_step));
        vx = qprod(vx, ldamp);
        vy = qprod(vy, ldamp);
        wr = qprod(w, adamp);
        px = sat(px + qprod(vx, it.time_step));
        py = sat(py + qprod(vy, it.time_step));
        ang = sat(ang + qprod(wr, it.time_step));
        if (absl(vx) < vmin) vx = 0;
        if (absl(vy) < vmin) vy = 0;
        if (absl(wr) < wmin) wr = 0;
        fax = 0; fay = 0; tacc = 0;
      end
    end else begin
      fax = sat(fax + it.push_x);
      fay = sat(fay + it.push_y);
      ax = sat(longint'(it.contact_x) - px);
      ay = sat(longint'(it.contact_y) - py);
      tacc = sat(tacc + sat(((ax * it.push_y) >>> RBI_FRAC_BITS) -
                            ((ay * it.push_x) >>> RBI_FRAC_BITS)));
    end
    r.position_x = px[31:0]; r.position_y = py[31:0]; r.heading = ang[31:0];
    r.velocity_x = vx[31:0]; r.velocity_y = vy[31:0]; r.spin_rate = wr[31:0];
    body_q.push_back(r);
  endtask

  // one transaction: random gap, then hold valid until accepted;
  // valid drops at the start of the next gap or in drain
  task automatic send_item(input in_item_t it);
    int gap;
    gap = $urandom_range(0, 14);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    predict_body(it);
  endtask

  task automatic write_reg(input logic [2:0] idx, input longint unsigned val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= RBI_ADDR_W'({idx, 2'b00}); pwdata <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_INV_MASS:    inv_m = val & 32'h7fffffff;
      REG_INV_INERTIA: inv_i = val & 32'h7fffffff;
      REG_MAX_LIN:     vmax  = val & 32'h7fffffff;
      REG_MAX_ANG:     wmax  = val & 32'h7fffffff;
      REG_LIN_DAMP:    ldamp = val & 32'h1ffff;
      REG_ANG_DAMP:    adamp = val & 32'h1ffff;
      REG_MIN_LIN:     vmin  = val & 32'h7fffffff;
      default:         wmin  = val & 32'h7fffffff;
    endcase
  endtask

  // wait until every result is in, then let a trailing transaction drain
  task automatic drain;
    in_valid_i <= 1'b0;
    while (body_q.size() != 0) @(posedge clk_i);
    repeat (800) @(posedge clk_i);
  endtask

  task automatic reg_setting(input longint unsigned m, ii, lmax, amax,
                             ld, ad, lmin, amin);
    drain();
    write_reg(REG_INV_MASS, m);    write_reg(REG_INV_INERTIA, ii);
    write_reg(REG_MAX_LIN, lmax);  write_reg(REG_MAX_ANG, amax);
    write_reg(REG_LIN_DAMP, ld);   write_reg(REG_ANG_DAMP, ad);
    write_reg(REG_MIN_LIN, lmin);  write_reg(REG_MIN_ANG, amin);
  endtask

  function automatic in_item_t mk(logic c, int fx, int fy, int cx, int cy,
                                  logic [15:0] dt);
    in_item_t it;
    it.command = c; it.push_x = fx; it.push_y = fy;
    it.contact_x = cx; it.contact_y = cy; it.time_step = dt;
    return it;
  endfunction

  function automatic int rand_val;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2: return int'($urandom_range(0, 2000)) - 1000;
      default: return (int'($urandom_range(0, 32'h1ffff)) - 32'h10000) <<< 4;
    endcase
  endfunction

  function automatic in_item_t rand_item;
    in_item_t it;
    it = mk(CMD_FORCE, rand_val(), rand_val(), rand_val(), rand_val(), 16'($urandom));
    if ($urandom_range(0, 2) == 0) begin
      it.command = CMD_INTEGRATE;
      if ($urandom_range(0, 1)) it.time_step = 16'($urandom_range(0, 16'h1000));
    end
    return it;
  endfunction

  // result checker: compares each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (body_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data_o);
        errors++;
      end else begin
        e = body_q.pop_front();
        if (out_data_o.position_x !== e.position_x) begin
          $display("%0t: position_x exp %h got %h", $time, e.position_x,
                   out_data_o.position_x); errors++;
        end
        if (out_data_o.position_y !== e.position_y) begin
          $display("%0t: position_y exp %h got %h", $time, e.position_y,
                   out_data_o.position_y); errors++;
        end
        if (out_data_o.heading !== e.heading) begin
          $display("%0t: heading exp %h got %h", $time, e.heading,
                   out_data_o.heading); errors++;
        end
        if (out_data_o.velocity_x !== e.velocity_x) begin
          $display("%0t: velocity_x exp %h got %h", $time, e.velocity_x,
                   out_data_o.velocity_x); errors++;
        end
        if (out_data_o.velocity_y !== e.velocity_y) begin
          $display("%0t: velocity_y exp %h got %h", $time, e.velocity_y,
                   out_data_o.velocity_y); errors++;
        end
        if (out_data_o.spin_rate !== e.spin_rate) begin
          $display("%0t: spin_rate exp %h got %h", $time, e.spin_rate,
                   out_data_o.spin_rate); errors++;
        end
      end
    end
  end

  // receiver stall: random per-result wait, or a long hold-off window
  initial begin
    int w;
    forever begin
      @(posedge clk_i);
      if (hold_off) out_stall_i <= 1'b1;
      else if (out_valid_o && !out_stall_i) begin
        w = $urandom_range(0, out_gap_max);
        out_stall_i <= (w != 0);
        if (w != 0) begin
          repeat (w) @(posedge clk_i);
          if (!hold_off) out_stall_i <= 1'b0;
        end
      end else if (!hold_off) out_stall_i <= 1'b0;
    end
  end

  task automatic test_directed;
    send_item(mk(CMD_FORCE, 32'h00010000, 32'h00020000, 32'h00030000, 0, 0));
    send_item(mk(CMD_INTEGRATE, 0, 0, 0, 0, 16'h8000));
    send_item(mk(CMD_FORCE, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0));
    send_item(mk(CMD_FORCE, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000, 0));
    send_item(mk(CMD_FORCE, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 0));
    send_item(mk(CMD_INTEGRATE, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                 32'hffffffff, 16'hffff));
    send_item(mk(CMD_INTEGRATE, 0, 0, 0, 0, 16'h0000));
    send_item(mk(CMD_INTEGRATE, 0, 0, 0, 0, 16'hffff));
  endtask

  task automatic test_frozen;
    reg_setting(0, 65536, 32'h7fffffff, 32'h7fffffff, 65536, 65536, 0, 0);
    send_item(mk(CMD_FORCE, 32'h00050000, -32'sh30000, 32'h00010000, 32'h00010000, 0));
    send_item(mk(CMD_INTEGRATE, 0, 0, 0, 0, 16'hffff));
    send_item(mk(CMD_FORCE, 32'h00010000, 0, 0, 32'h00020000, 0));
  endtask

  task automatic test_clamps;
    // low speed caps, damping above and below one, sleep thresholds
    reg_setting(32'h7fffffff, 32'h7fffffff, 32'h00008000, 32'h00004000,
                32'h1ffff, 0, 32'h00000100, 32'h00000100);
    repeat (12) send_item(rand_item());
    reg_setting(32'h00020000, 32'h00000100, 0, 0, 32'h0c000, 65536,
                32'h7fffffff, 32'h7fffffff);
    repeat (8) send_item(rand_item());
  endtask

  task automatic test_random(input int n);
    repeat (n) send_item(rand_item());
  endtask

  // fill the block while the receiver holds off
  task automatic test_backpressure;
    hold_off = 1'b1;
    fork
      repeat (4) send_item(rand_item());
      begin
        repeat (6000) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
  endtask

  initial begin
    inv_m = 65536; inv_i = 65536; vmax = 32'h7fffffff; wmax = 32'h7fffffff;
    ldamp = 65536; adamp = 65536; vmin = 0; wmin = 0;
    fax = 0; fay = 0; tacc = 0; px = 0; py = 0; ang = 0; vx = 0; vy = 0; wr = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_frozen();
    test_clamps();
    reg_setting(65536, 65536, 32'h7fffffff, 32'h7fffffff, 65536, 65536, 0, 0);
    test_random(250);
    test_backpressure();
    reg_setting($urandom_range(1, 32'h40000), $urandom_range(0, 32'h40000),
                $urandom_range(0, 32'h1000000), $urandom_range(0, 32'h1000000),
                $urandom_range(0, 65536), $urandom_range(0, 65536),
                $urandom_range(0, 64), $urandom_range(0, 64));
    test_random(250);
    out_gap_max = 0;
    test_random(120);
    out_gap_max = 14;
    reg_setting($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 65536),
                $urandom_range(0, 65536), $urandom_range(0, 255), $urandom_range(0, 255));
    test_random(150);
    drain();
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
